// File: rtl/core/vector3_normalize_unit_assert.svh
// Assertion macros shared by the vector normalize RTL.
`ifndef VECTOR3_NORMALIZE_UNIT_ASSERT_SVH
`define VECTOR3_NORMALIZE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every edge outside reset.
`define V3N_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define V3N_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/v3n_pkg.sv
// Shared constants and types of the vector normalize unit.
package v3n_pkg;

  // One root bit per square-root stage, one quotient bit per divide stage.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  // Values that ride along the square-root pipeline.
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] absv;
    logic             zero;
  } side_t;

  // Values that ride along the divide pipeline.
  typedef struct packed {
    logic [2:0]  neg;
    logic        zero;
    logic [31:0] mag;
  } tail_t;

endpackage

// File: rtl/core/v3n_in_if.sv
// Input channel: one 3D vector per item.
interface v3n_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

// File: rtl/core/v3n_out_if.sv
// Output channel: length and unit vector per item.
interface v3n_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] magnitude;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic               zero_vector;

  modport source (output valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                  input ready);
  modport sink (input valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                output ready);
endinterface

// File: rtl/core/v3n_sqrt_pipe.sv
// Pipelined exact integer square root, one root bit per stage.
module v3n_sqrt_pipe import v3n_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] root,
  output side_t       out_side
);

  logic [SQRT_STEPS:0] vld;
  logic [63:0]         rem  [SQRT_STEPS+1];
  logic [63:0]         acc  [SQRT_STEPS+1];
  side_t               side [SQRT_STEPS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = radicand;
  assign acc[0]  = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        fits;

    // Try setting this root bit
    always_comb begin
      trial = acc[i] + BIT;
      fits  = rem[i] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[i+1]  <= fits ? rem[i] - trial : rem[i];
        acc[i+1]  <= fits ? (acc[i] >> 1) + BIT : acc[i] >> 1;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign root      = acc[SQRT_STEPS][31:0];
  assign out_side  = side[SQRT_STEPS];

endmodule

// File: rtl/core/v3n_div_pipe.sv
// Pipelined restoring divider: (num << 30) / den, one quotient bit per stage.
module v3n_div_pipe import v3n_pkg::*; (
  input  logic                 clk,
  input  logic                 advance,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output logic [DIV_STEPS-1:0] quot
);

  logic [32:0]          rem [DIV_STEPS+1];
  logic [31:0]          dv  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q   [DIV_STEPS+1];

  // num never exceeds den, so the first step needs no shift
  assign rem[0] = {1'b0, num};
  assign dv[0]  = den;
  assign q[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [32:0] part;
    logic        fits;

    always_comb begin
      if (k == 0) begin
        part = rem[k];
      end else begin
        part = {rem[k][31:0], 1'b0};
      end
      fits = part >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k+1] <= fits ? part - {1'b0, dv[k]} : part;
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][DIV_STEPS-2:0], fits};
      end
    end
  end

  assign quot = q[DIV_STEPS];

endmodule

// File: rtl/core/vector3_normalize_unit.sv
// Vector normalize unit: length and unit vector of a Q16.16 3D vector.
// Takes one vector per cycle while the output is not stalled and returns one result per
// vector, in order. Between acceptance and result lie the registers for magnitudes,
// squares and their sum, the square root (one root bit per stage), the three parallel
// dividers (one quotient bit per stage) and the output register. A stall at the output
// freezes the whole pipeline. The length is the floor of the exact root; unit
// components are truncated toward zero in Q2.30.
// An all-zero vector gives zero length, zero components and zero_vector set.
module vector3_normalize_unit import v3n_pkg::*; (
  input logic     clk,
  input logic     rst,
  v3n_in_if.sink  vin,
  v3n_out_if.source vout
);

  logic advance;

  // Whole pipeline moves when the output register is free or being taken
  assign advance   = !vout.valid || vout.ready;
  assign vin.ready = advance;

  // Stage 1: magnitudes and signs
  logic  s1_valid;
  side_t s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= vin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_side.neg     <= {vin.comp_z[31], vin.comp_y[31], vin.comp_x[31]};
      s1_side.absv[0] <= vin.comp_x[31] ? 32'(-vin.comp_x) : vin.comp_x;
      s1_side.absv[1] <= vin.comp_y[31] ? 32'(-vin.comp_y) : vin.comp_y;
      s1_side.absv[2] <= vin.comp_z[31] ? 32'(-vin.comp_z) : vin.comp_z;
      s1_side.zero    <= (vin.comp_x == '0) && (vin.comp_y == '0) && (vin.comp_z == '0);
    end
  end

  // Stage 2: squares
  logic        s2_valid;
  side_t       s2_side;
  logic [63:0] sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_side <= s1_side;
      sq[0]   <= 64'(s1_side.absv[0]) * 64'(s1_side.absv[0]);
      sq[1]   <= 64'(s1_side.absv[1]) * 64'(s1_side.absv[1]);
      sq[2]   <= 64'(s1_side.absv[2]) * 64'(s1_side.absv[2]);
    end
  end

  // Stage 3: sum of squares (at most 3 * 2^62, fits 64 bits)
  logic        s3_valid;
  side_t       s3_side;
  logic [63:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_side <= s2_side;
      sum     <= sq[0] + sq[1] + sq[2];
    end
  end

  // Square root
  logic        rt_valid;
  logic [31:0] rt_mag;
  side_t       rt_side;

  v3n_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s3_valid),
    .radicand  (sum),
    .in_side   (s3_side),
    .out_valid (rt_valid),
    .root      (rt_mag),
    .out_side  (rt_side)
  );

  // Three dividers in parallel
  logic [DIV_STEPS-1:0] quot [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    v3n_div_pipe u_div (
      .clk     (clk),
      .advance (advance),
      .num     (rt_side.absv[j]),
      .den     (rt_mag),
      .quot    (quot[j])
    );
  end

  // Sideband delay matching the dividers
  logic [DIV_STEPS:0] tv;
  tail_t              tl [DIV_STEPS+1];

  assign tv[0]      = rt_valid;
  assign tl[0].neg  = rt_side.neg;
  assign tl[0].zero = rt_side.zero;
  assign tl[0].mag  = rt_mag;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[k+1] <= 1'b0;
      end else if (advance) begin
        tv[k+1] <= tv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        tl[k+1] <= tl[k];
      end
    end
  end

  // Output register: apply signs, clear a zero vector
  logic [31:0] unit_val [3];
  tail_t       tail_end;

  assign tail_end = tl[DIV_STEPS];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (tail_end.zero) begin
        unit_val[j] = '0;
      end else if (tail_end.neg[j]) begin
        unit_val[j] = 32'(-{1'b0, quot[j]});
      end else begin
        unit_val[j] = {1'b0, quot[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout.valid <= 1'b0;
    end else if (advance) begin
      vout.valid <= tv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vout.magnitude   <= tail_end.zero ? '0 : tail_end.mag;
      vout.unit_x      <= unit_val[0];
      vout.unit_y      <= unit_val[1];
      vout.unit_z      <= unit_val[2];
      vout.zero_vector <= tail_end.zero;
    end
  end

  // Result properties checked below
  logic out_stall;
  logic zero_clear;
  logic units_ok;

  assign out_stall  = vout.valid && !vout.ready;
  assign zero_clear = (vout.magnitude == '0) && (vout.unit_x == '0) &&
                      (vout.unit_y == '0) && (vout.unit_z == '0);
  assign units_ok   = (vout.unit_x <= 32'sd1073741824) && (vout.unit_x >= -32'sd1073741824) &&
                      (vout.unit_y <= 32'sd1073741824) && (vout.unit_y >= -32'sd1073741824) &&
                      (vout.unit_z <= 32'sd1073741824) && (vout.unit_z >= -32'sd1073741824);

`include "vector3_normalize_unit_assert.svh"

  `V3N_ASSERT_NOW(a_zero_clears, vout.valid && vout.zero_vector, zero_clear, "zero not cleared")
  `V3N_ASSERT_NOW(a_nonzero_len, vout.valid && !vout.zero_vector, vout.magnitude != '0, "zero len")
  `V3N_ASSERT_NOW(a_unit_range, vout.valid, units_ok, "unit component out of range")
  `V3N_ASSERT_NEXT(a_stall_freeze, out_stall, vout.valid && $stable(tv) && $stable(s1_valid), "moved")

endmodule

// File: sim/v3n_check.sv
// Checker for the vector normalize unit: predicts length and unit vector, compares results.
`timescale 1ns / 100ps
module v3n_check (
  input  logic      clk,
  input  logic      rst,
  v3n_in_if         vin,
  v3n_out_if        vout,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [31:0] magnitude;
    logic [31:0] unit_x;
    logic [31:0] unit_y;
    logic [31:0] unit_z;
    logic        zero_vector;
  } norm_t;

  norm_t norm_q[$];

  assign pending = norm_q.size();

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Floor square root, one root bit per step.
  function automatic logic [63:0] floor_root(logic [63:0] s);
    logic [63:0] rem, root, b;
    rem = s;
    root = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Q2.30 quotient on magnitudes, sign applied after.
  function automatic logic [31:0] unit_comp(logic [31:0] c, logic [63:0] len);
    logic [63:0] q;
    q = ({32'd0, abs32(c)} << 30) / len;
    if (c[31]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_t r;
    logic [63:0] ax, ay, az, sum, len;
    ax = {32'd0, abs32(x)};
    ay = {32'd0, abs32(y)};
    az = {32'd0, abs32(z)};
    sum = ax * ax + ay * ay + az * az;
    if (sum == 64'd0) begin
      r = '0;
      r.zero_vector = 1'b1;
    end else begin
      len = floor_root(sum);
      r.magnitude = len[31:0];
      r.unit_x = unit_comp(x, len);
      r.unit_y = unit_comp(y, len);
      r.unit_z = unit_comp(z, len);
      r.zero_vector = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    norm_t w;
    if (!rst) begin
      if (vin.valid && vin.ready)
        norm_q.push_back(normalize(vin.comp_x, vin.comp_y, vin.comp_z));
      if (vout.valid && vout.ready) begin
        if (norm_q.size() == 0) begin
          report("unexpected item", vout.magnitude, 32'd0);
        end else begin
          w = norm_q.pop_front();
          if (vout.magnitude !== w.magnitude) report("magnitude", vout.magnitude, w.magnitude);
          if (vout.unit_x !== w.unit_x) report("unit_x", vout.unit_x, w.unit_x);
          if (vout.unit_y !== w.unit_y) report("unit_y", vout.unit_y, w.unit_y);
          if (vout.unit_z !== w.unit_z) report("unit_z", vout.unit_z, w.unit_z);
          if (vout.zero_vector !== w.zero_vector)
            report("zero_vector", {31'd0, vout.zero_vector}, {31'd0, w.zero_vector});
        end
      end
    end
  end

endmodule

// File: sim/tb_vector3_normalize_unit.sv
// Top testbench of the vector normalize unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_vector3_normalize_unit;

  localparam int RANDOM_ITEMS = 1080;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 150;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   cyc;
  bit   stim_done;
  bit   calm;
  bit   hold_off;

  v3n_in_if  vin ();
  v3n_out_if vout ();

  vector3_normalize_unit dut (.clk(clk), .rst(rst), .vin(vin), .vout(vout));
  v3n_check chk (.clk(clk), .rst(rst), .vin(vin), .vout(vout),
                 .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle count drives the calm stretch and the long receiver hold-off.
  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc > 300 && cyc < 600);

  initial begin
    hold_off = 1'b0;
    wait (cyc == 900);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Receiver: random stalls at the falling edge.
  always @(negedge clk) begin
    if (rst || hold_off) vout.ready <= 1'b0;
    else if (calm) vout.ready <= 1'b1;
    else vout.ready <= ($urandom_range(99) >= 33);
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(255) - 128;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item; valid drops only in idle cycles between items.
  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (!calm && $urandom_range(99) < 33) begin
      vin.valid <= 1'b0;
      @(negedge clk);
    end
    vin.valid <= 1'b1;
    vin.comp_x <= x;
    vin.comp_y <= y;
    vin.comp_z <= z;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    cyc = 0;
    stim_done = 1'b0;
    rst = 1'b1;
    vin.valid = 1'b0;
    vin.comp_x = '0;
    vin.comp_y = '0;
    vin.comp_z = '0;
    vout.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // Directed: zero vector, extremes, single axes, most negative values.
    send(32'd0, 32'd0, 32'd0);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'd0, 32'd0);
    send(32'd0, 32'h8000_0000, 32'd0);
    send(32'd0, 32'd0, 32'h8000_0000);
    send(32'h7fff_ffff, 32'd0, 32'd0);
    send(32'd1, 32'd0, 32'd0);
    send(32'hffff_ffff, 32'd0, 32'd0);
    send(32'd0, 32'hffff_ffff, 32'd1);
    send(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(32'hffff_0000, 32'h0002_0000, 32'hfffe_0000);
    send(32'h0003_0000, 32'h0004_0000, 32'd0);
    send(32'h8000_0000, 32'h7fff_ffff, 32'd1);
    send(32'd1, 32'd1, 32'd1);
    send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send(rand_comp(), rand_comp(), rand_comp());
    vin.valid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[vector3_normalize_unit] OK");
    else
      $display("[vector3_normalize_unit] ERROR");
    $finish;
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (vout.valid && vout.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[vector3_normalize_unit] ERROR");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
